// File: src/ttc_forward_collision_warning_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the time-to-collision warning core
// Same-cycle-implication and next-cycle-implication checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef TTC_FORWARD_COLLISION_WARNING_CORE_ASSERT_SVH
`define TTC_FORWARD_COLLISION_WARNING_CORE_ASSERT_SVH

// Same-cycle implication
`define TTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ttc_fcw_pkg.sv
// ----------------------------------------------------------------------------
// ttc_fcw_pkg
// Shared widths, constants and types of the time-to-collision warning core.
// ----------------------------------------------------------------------------
package ttc_fcw_pkg;

  // Latch table size and index width
  localparam int unsigned TRACK_SLOTS = 256;
  localparam int unsigned SLOT_W      = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

  // Field widths
  localparam int unsigned ID_W   = 8;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned VEL_W  = 16;
  localparam int unsigned TTC_W  = 16;
  localparam int unsigned SEV_W  = 12;
  localparam int unsigned AX_W   = POS_W;
  localparam int unsigned AV_W   = VEL_W;
  localparam int unsigned IN_W   = 48;
  localparam int unsigned OUT_W  = 40;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TTC_LIMIT   = 1'b0,
    CFG_RISING_EDGE = 1'b1
  } cfg_idx_e;

  localparam logic [TTC_W-1:0] TTC_LIMIT_RST = 16'd640;
  localparam logic             RISING_RST    = 1'b1;

  // Closing when velocity is at or below -26 raw (faster than 0.1 m/s)
  localparam logic signed [VEL_W-1:0] CLOSING_LIMIT = -16'sd26;
  localparam logic [SEV_W-1:0]        SEV_MAX       = 12'd2560;

  // Serial divider: both quotients are known to fit in DIV_STEPS bits
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [AX_W-1:0] ax;
    logic [AV_W-1:0] av;
  } fcw_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

// File: src/ttc_forward_collision_warning_core.sv
// Flow: an accepted track is classified, queued, put through the 16-step
//   division and placed in the output register; a track without a warning is dropped.
//   The classifier holds one track and takes no new one until it is done; the
//   bit-serial divider takes the next warning only once the last is in the output register.
// Reset: threshold 2.5 s and rising-edge mode are restored; a sweep then
//   clears all 256 zone latches with s_axis_tready held low.
// ----------------------------------------------------------------------------
// ttc_forward_collision_warning_core
// Forward collision warning by time to collision on tracked objects.
// ----------------------------------------------------------------------------
`include "ttc_forward_collision_warning_core_assert.svh"

module ttc_forward_collision_warning_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // s_axis_tdata: object_id[7:0], rel_position[31:8], rel_velocity[47:32]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ttc_fcw_pkg::IN_W-1:0]         s_axis_tdata,
  // m_axis_tdata: warn_id[7:0], warn_severity[19:8], warn_ttc[35:20], zero pad
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ttc_fcw_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [ttc_fcw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ttc_fcw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [ttc_fcw_pkg::TTC_W-1:0]   ttc_limit_q;
  logic                            rising_q;
  ttc_fcw_pkg::queue_stat_t        q_stat;
  logic                            q_push;
  logic                            q_pop;
  ttc_fcw_pkg::fcw_item_t          push_item;
  ttc_fcw_pkg::fcw_item_t          head_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttc_limit_q <= ttc_fcw_pkg::TTC_LIMIT_RST;
      rising_q    <= ttc_fcw_pkg::RISING_RST;
    end else if (cfg_we_i) begin
      unique case (ttc_fcw_pkg::cfg_idx_e'(cfg_idx_i))
        ttc_fcw_pkg::CFG_TTC_LIMIT:   ttc_limit_q <= cfg_data_i;
        ttc_fcw_pkg::CFG_RISING_EDGE: rising_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ttc_fcw_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .ttc_limit_i        (ttc_limit_q),
    .rising_edge_only_i (rising_q),
    .q_stat_i           (q_stat),
    .q_push_o           (q_push),
    .q_item_o           (push_item)
  );

  ttc_fcw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .item_o (head_item)
  );

  ttc_fcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_item_i      (head_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Checks
  `TTC_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  `TTC_ASSERT_IMP(a_no_pop_empty, q_pop, q_stat.valid, "pop from empty queue")
  `TTC_ASSERT_IMP(a_sev_range, m_axis_tvalid, m_axis_tdata[19:8] <= ttc_fcw_pkg::SEV_MAX, "bad sev")
  `TTC_ASSERT_NXT(a_front_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "front took two tracks")

endmodule

// File: src/ttc_fcw_front.sv
// ----------------------------------------------------------------------------
// ttc_fcw_front
// Accepts tracks, runs the closing and zone tests, keeps the per-track zone
// latches and queues the tracks that must raise a warning.
// ----------------------------------------------------------------------------
module ttc_fcw_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ttc_fcw_pkg::IN_W-1:0]        s_axis_tdata,
  input  logic [ttc_fcw_pkg::TTC_W-1:0]       ttc_limit_i,
  input  logic                                rising_edge_only_i,
  input  ttc_fcw_pkg::queue_stat_t            q_stat_i,
  output logic                                q_push_o,
  output ttc_fcw_pkg::fcw_item_t              q_item_o
);

  logic                                    valid_q;
  logic [ttc_fcw_pkg::ID_W-1:0]            id_q;
  logic [ttc_fcw_pkg::POS_W-1:0]           pos_q;
  logic [ttc_fcw_pkg::VEL_W-1:0]           vel_q;
  logic                                    latch_q [ttc_fcw_pkg::TRACK_SLOTS];
  logic                                    latch_rd_q;
  logic                                    clr_q;
  logic [ttc_fcw_pkg::SLOT_W-1:0]          clr_idx_q;

  logic                                    accept;
  logic [ttc_fcw_pkg::AX_W-1:0]            ax;
  logic [ttc_fcw_pkg::AV_W-1:0]            av;
  logic                                    closing;
  logic [31:0]                             prod;
  logic [31:0]                             scaled;
  logic                                    in_zone;
  logic [ttc_fcw_pkg::SLOT_W-1:0]          slot;
  logic [ttc_fcw_pkg::SLOT_W-1:0]          in_slot;
  logic                                    emit;
  logic                                    done;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !valid_q && !clr_q;

  // Magnitudes of position and velocity
  assign ax = pos_q[ttc_fcw_pkg::POS_W-1] ? (~pos_q + 1'b1) : pos_q;
  assign av = vel_q[ttc_fcw_pkg::VEL_W-1] ? (~vel_q + 1'b1) : vel_q;

  // Closing and zone tests: |x|*256 < limit*|v|
  assign closing = $signed(vel_q) <= ttc_fcw_pkg::CLOSING_LIMIT;
  assign prod    = {16'b0, ttc_limit_i} * {16'b0, av};
  assign scaled  = {ax, 8'b0};
  assign in_zone = closing && (scaled < prod);

  assign slot    = ttc_fcw_pkg::SLOT_W'(id_q % ttc_fcw_pkg::TRACK_SLOTS);
  assign in_slot = ttc_fcw_pkg::SLOT_W'(s_axis_tdata[7:0] % ttc_fcw_pkg::TRACK_SLOTS);
  assign emit    = in_zone && !(rising_edge_only_i && latch_rd_q);
  assign done    = valid_q && (!emit || !q_stat_i.full);

  assign q_push_o    = valid_q && emit && !q_stat_i.full;
  assign q_item_o.id = id_q;
  assign q_item_o.ax = ax;
  assign q_item_o.av = av;

  // Hold one track until it is classified
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (done) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the track and read its zone latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q       <= s_axis_tdata[7:0];
      pos_q      <= s_axis_tdata[31:8];
      vel_q      <= s_axis_tdata[47:32];
      latch_rd_q <= latch_q[in_slot];
    end
  end

  // Sweep the zone latches to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == ttc_fcw_pkg::SLOT_W'(ttc_fcw_pkg::TRACK_SLOTS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Update the zone latch when the track leaves the front
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      latch_q[clr_idx_q] <= 1'b0;
    end else if (done) begin
      latch_q[slot] <= in_zone;
    end
  end

endmodule

// File: src/ttc_fcw_queue.sv
// ----------------------------------------------------------------------------
// ttc_fcw_queue
// Short FIFO of pending warnings between the classifier and the divider.
// ----------------------------------------------------------------------------
module ttc_fcw_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ttc_fcw_pkg::fcw_item_t     item_i,
  input  logic                       pop_i,
  output ttc_fcw_pkg::queue_stat_t   stat_o,
  output ttc_fcw_pkg::fcw_item_t     item_o
);

  ttc_fcw_pkg::fcw_item_t              mem_q [ttc_fcw_pkg::QUEUE_DEPTH];
  logic [ttc_fcw_pkg::QPTR_W-1:0]      wr_ptr_q;
  logic [ttc_fcw_pkg::QPTR_W-1:0]      rd_ptr_q;
  logic [ttc_fcw_pkg::QCNT_W-1:0]      cnt_q;
  logic                                do_push;
  logic                                do_pop;

  assign stat_o.full  = cnt_q == ttc_fcw_pkg::QCNT_W'(ttc_fcw_pkg::QUEUE_DEPTH);
  assign stat_o.valid = cnt_q != '0;
  assign item_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.valid;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == ttc_fcw_pkg::QPTR_W'(ttc_fcw_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ttc_fcw_pkg::QPTR_W'(ttc_fcw_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/ttc_fcw_back.sv
// ----------------------------------------------------------------------------
// ttc_fcw_back
// Runs the two serial divisions (time to collision and severity) one bit a
// cycle and holds the finished warning in the output register.
// ----------------------------------------------------------------------------
module ttc_fcw_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ttc_fcw_pkg::queue_stat_t        q_stat_i,
  input  ttc_fcw_pkg::fcw_item_t          q_item_i,
  output logic                            q_pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ttc_fcw_pkg::OUT_W-1:0]   m_axis_tdata
);

  ttc_fcw_pkg::back_state_e               state_q, state_d;
  logic [ttc_fcw_pkg::CNT_W-1:0]          cnt_q;
  logic [ttc_fcw_pkg::ID_W-1:0]           id_q;
  logic [ttc_fcw_pkg::AX_W-1:0]           ax_q;
  logic [ttc_fcw_pkg::AV_W-1:0]           av_q;
  logic                                   sat_q;
  logic [ttc_fcw_pkg::AV_W-1:0]           rem_t_q;
  logic [ttc_fcw_pkg::DIV_STEPS-1:0]      quo_t_q;
  logic [ttc_fcw_pkg::AX_W-1:0]           rem_s_q;
  logic [ttc_fcw_pkg::DIV_STEPS-1:0]      quo_s_q;

  logic                                   out_valid_q;
  logic [ttc_fcw_pkg::ID_W-1:0]           out_id_q;
  logic [ttc_fcw_pkg::SEV_W-1:0]          out_sev_q;
  logic [ttc_fcw_pkg::TTC_W-1:0]          out_ttc_q;

  logic                                   load;
  logic                                   step;
  logic                                   emit;
  logic                                   last_step;
  logic [27:0]                            ax10;
  logic [ttc_fcw_pkg::AV_W:0]             t_ttc;
  logic                                   ge_t;
  logic [ttc_fcw_pkg::AX_W:0]             t_sev;
  logic                                   ge_s;

  assign last_step = cnt_q == ttc_fcw_pkg::CNT_W'(ttc_fcw_pkg::DIV_STEPS - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttc_fcw_pkg::BK_IDLE: begin
        if (q_stat_i.valid) state_d = ttc_fcw_pkg::BK_DIV;
      end
      ttc_fcw_pkg::BK_DIV: begin
        if (last_step) state_d = ttc_fcw_pkg::BK_DONE;
      end
      ttc_fcw_pkg::BK_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ttc_fcw_pkg::BK_IDLE;
      end
      default: state_d = ttc_fcw_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    load = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    unique case (state_q)
      ttc_fcw_pkg::BK_IDLE: load = q_stat_i.valid;
      ttc_fcw_pkg::BK_DIV:  step = 1'b1;
      ttc_fcw_pkg::BK_DONE: emit = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign q_pop_o = load;

  // Severity saturates when 10*|x| < |v|
  assign ax10 = 28'({q_item_i.ax, 3'b0}) + 28'({q_item_i.ax, 1'b0});

  // One restoring step per lane
  assign t_ttc = {rem_t_q, quo_t_q[ttc_fcw_pkg::DIV_STEPS-1]};
  assign ge_t  = t_ttc >= {1'b0, av_q};
  assign t_sev = {rem_s_q, quo_s_q[ttc_fcw_pkg::DIV_STEPS-1]};
  assign ge_s  = t_sev >= {1'b0, ax_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttc_fcw_pkg::BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Divider datapath: ttc = |x|*256/|v|, severity = |v|*256/|x|
  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q    <= q_item_i.id;
      ax_q    <= q_item_i.ax;
      av_q    <= q_item_i.av;
      sat_q   <= ax10 < 28'(q_item_i.av);
      rem_t_q <= 16'(q_item_i.ax[23:8]);
      quo_t_q <= {q_item_i.ax[7:0], 8'h00};
      rem_s_q <= 24'(q_item_i.av[15:8]);
      quo_s_q <= {q_item_i.av[7:0], 8'h00};
    end else if (step) begin
      rem_t_q <= ge_t ? 16'(t_ttc - {1'b0, av_q}) : t_ttc[15:0];
      quo_t_q <= {quo_t_q[ttc_fcw_pkg::DIV_STEPS-2:0], ge_t};
      rem_s_q <= ge_s ? 24'(t_sev - {1'b0, ax_q}) : t_sev[23:0];
      quo_s_q <= {quo_s_q[ttc_fcw_pkg::DIV_STEPS-2:0], ge_s};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_id_q  <= id_q;
      out_sev_q <= sat_q ? ttc_fcw_pkg::SEV_MAX : quo_s_q[ttc_fcw_pkg::SEV_W-1:0];
      out_ttc_q <= quo_t_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_ttc_q, out_sev_q, out_id_q};

endmodule
